// ----- hdl/b64u_pkg.sv -----
// Shared types, character codes and the base64url alphabet lookup for the
// base64url stream encoder. No dependencies.
`default_nettype none

package b64u_pkg;

    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd49;

    localparam logic [CHAR_W-1:0] CHAR_TERM  = 7'h3D;  // '='
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 7'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CHAR_UNDER = 7'h5F;  // '_'

    // Bits left over from earlier bytes of the run: none, two or four
    typedef enum logic [1:0] {
        LEFT_0,
        LEFT_2,
        LEFT_4
    } t_left;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic               run_end;
        logic               overflow;
        logic [LIMIT_W-1:0] char_count;
    } t_result;

    function automatic logic [CHAR_W-1:0] b64u_char(input logic [5:0] idx);
        logic [CHAR_W-1:0] c;
        if (idx < 6'd26) begin
            c = CHAR_UPPER + {1'b0, idx};
        end else if (idx < 6'd52) begin
            c = CHAR_LOWER + {1'b0, idx} - 7'd26;
        end else if (idx < 6'd62) begin
            c = CHAR_DIGIT + {1'b0, idx} - 7'd52;
        end else if (idx == 6'd62) begin
            c = CHAR_DASH;
        end else begin
            c = CHAR_UNDER;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/b64u_in_if.sv -----
// Input byte channel of the base64url encoder: valid/ready plus one byte and
// its last-byte flag. No dependencies.
`default_nettype none

interface b64u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/b64u_out_if.sv -----
// Result channel of the base64url encoder: valid/ready plus one character
// item. Depends on b64u_pkg.
`default_nettype none

interface b64u_out_if;
    import b64u_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   out_char;
    logic                run_end;
    logic                overflow;
    logic [LIMIT_W-1:0]  char_count;

    modport source (output valid, output out_char, output run_end, output overflow,
                    output char_count, input ready);
    modport sink   (input valid, input out_char, input run_end, input overflow,
                    input char_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/b64u_cfg_if.sv -----
// Configuration write channel of the base64url encoder: valid/ready plus the
// output limit. Depends on b64u_pkg.
`default_nettype none

interface b64u_cfg_if;
    import b64u_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] out_limit;

    modport source (output valid, output out_limit, input ready);
    modport sink   (input valid, input out_limit, output ready);
endinterface

`default_nettype wire

// ----- hdl/b64u_step.sv -----
// Input register, run state and per-character result generation of the
// base64url encoder. Depends on b64u_pkg and b64u_in_if.
`default_nettype none

module b64u_step (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    b64u_in_if.sink                       i_in,
    input  wire logic [b64u_pkg::LIMIT_W-1:0] i_out_limit,
    input  wire logic                     i_res_ready,
    output logic                          o_res_valid,
    output b64u_pkg::t_result             o_res
);
    import b64u_pkg::*;

    // Held item
    logic               r_in_valid;
    logic [7:0]         r_byte;
    logic               r_final;
    logic [1:0]         r_sub;

    // Run state
    t_left              r_left;
    logic [3:0]         r_left_bits;
    logic [LIMIT_W-1:0] r_emitted;
    logic               r_dropping;

    t_left              n_left;
    logic [3:0]         n_left_bits;
    logic [LIMIT_W-1:0] n_emitted;
    logic               n_dropping;

    logic [CHAR_W-1:0]  ch0, ch1, ch2, sel_ch;
    logic [1:0]         last_idx;
    t_left              left_after;
    logic [3:0]         bits_after;
    logic [LIMIT_W:0]   count_sum;
    logic [LIMIT_W:0]   count_inc;
    logic               room;
    logic               last_sub;
    logic               step_fire;
    logic               item_done;

    // Characters this byte would give if the limit allows all of them
    always_comb begin
        ch0        = CHAR_NONE;
        ch1        = CHAR_NONE;
        ch2        = CHAR_TERM;
        left_after = LEFT_0;
        bits_after = 4'd0;
        case (r_left)
            LEFT_0: begin
                ch0        = b64u_char(r_byte[7:2]);
                ch1        = b64u_char({r_byte[1:0], 4'd0});
                left_after = LEFT_2;
                bits_after = {2'd0, r_byte[1:0]};
            end
            LEFT_2: begin
                ch0        = b64u_char({r_left_bits[1:0], r_byte[7:4]});
                ch1        = b64u_char({r_byte[3:0], 2'd0});
                left_after = LEFT_4;
                bits_after = r_byte[3:0];
            end
            LEFT_4: begin
                ch0        = b64u_char({r_left_bits, r_byte[7:6]});
                ch1        = b64u_char(r_byte[5:0]);
                left_after = LEFT_0;
                bits_after = 4'd0;
            end
            default: begin
                ch0        = CHAR_NONE;
                ch1        = CHAR_NONE;
                left_after = LEFT_0;
                bits_after = 4'd0;
            end
        endcase

        if (r_final) begin
            last_idx = 2'd2;
        end else if (r_left == LEFT_4) begin
            last_idx = 2'd1;
        end else begin
            last_idx = 2'd0;
        end

        case (r_sub)
            2'd0:    sel_ch = ch0;
            2'd1:    sel_ch = ch1;
            2'd2:    sel_ch = ch2;
            default: sel_ch = CHAR_NONE;
        endcase
    end

    assign count_sum = {1'b0, r_emitted} + {{(LIMIT_W-1){1'b0}}, r_sub};
    assign count_inc = count_sum + {{LIMIT_W{1'b0}}, 1'b1};
    assign room      = count_sum < {1'b0, i_out_limit};
    assign last_sub  = (r_sub == last_idx);

    // A dropped byte needs no result slot
    assign step_fire = r_in_valid && (r_dropping || i_res_ready);
    assign item_done = step_fire && (r_dropping || !room || last_sub);

    assign i_in.ready  = !r_in_valid || item_done;
    assign o_res_valid = r_in_valid && !r_dropping;

    always_comb begin
        if (room) begin
            o_res.out_char   = sel_ch;
            o_res.run_end    = r_final && last_sub;
            o_res.overflow   = 1'b0;
            o_res.char_count = count_inc[LIMIT_W-1:0];
        end else begin
            o_res.out_char   = CHAR_NONE;
            o_res.run_end    = 1'b1;
            o_res.overflow   = 1'b1;
            o_res.char_count = count_sum[LIMIT_W-1:0];
        end
    end

    // Run state after the held item completes
    always_comb begin
        n_left      = r_left;
        n_left_bits = r_left_bits;
        n_emitted   = r_emitted;
        n_dropping  = r_dropping;
        if (item_done) begin
            if (r_dropping) begin
                if (r_final) begin
                    n_dropping  = 1'b0;
                    n_left      = LEFT_0;
                    n_left_bits = 4'd0;
                    n_emitted   = '0;
                end
            end else if (!room || r_final) begin
                n_dropping  = !room && !r_final;
                n_left      = LEFT_0;
                n_left_bits = 4'd0;
                n_emitted   = '0;
            end else begin
                n_left      = left_after;
                n_left_bits = bits_after;
                n_emitted   = count_inc[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_sub       <= 2'd0;
            r_left      <= LEFT_0;
            r_left_bits <= 4'd0;
            r_emitted   <= '0;
            r_dropping  <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_left_bits <= n_left_bits;
            r_emitted   <= n_emitted;
            r_dropping  <= n_dropping;
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (item_done) begin
                r_in_valid <= 1'b0;
            end
            if (item_done) begin
                r_sub <= 2'd0;
            end else if (step_fire) begin
                r_sub <= r_sub + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte  <= i_in.data_byte;
            r_final <= i_in.final_byte;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/b64u_out_reg.sv -----
// Output register of the base64url encoder: holds one result item until the
// sink takes it. Depends on b64u_pkg and b64u_out_if.
`default_nettype none

module b64u_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  b64u_pkg::t_result      i_res,
    output logic                   o_res_ready,
    b64u_out_if.source             o_out
);
    import b64u_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid && o_res_ready) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_char   = r_res.out_char;
    assign o_out.run_end    = r_res.run_end;
    assign o_out.overflow   = r_res.overflow;
    assign o_out.char_count = r_res.char_count;

endmodule

`default_nettype wire

// ----- hdl/base64url_stream_encoder.sv -----
// Top level of the base64url stream encoder: limit register, step unit and
// output register. Depends on b64u_pkg, the three channel interfaces,
// b64u_step and b64u_out_reg.
//
// Encodes a message, one byte per item, into URL-safe base64 characters, one
// per result item, closing each run with '=' (run_end set). A byte gives one
// or two characters, the last byte of a message up to three. A run that would
// pass out_limit characters ends with a single overflow item (out_char 0,
// run_end and overflow set) and the rest of that message is dropped. The
// result channel carries one character per cycle while the output register
// can take it; a byte is held until it has given all its results (1 to 3),
// and a dropped byte needs no result slot. A byte is first captured in the
// input register, and its results then go to the output register. The
// configuration channel is always ready; write it only while the block is idle.
`default_nettype none

module base64url_stream_encoder (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    b64u_in_if.sink      i_in,
    b64u_cfg_if.sink     i_cfg,
    b64u_out_if.source   o_out
);
    import b64u_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               res_valid;
    logic               res_ready;
    t_result            res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_limit <= i_cfg.out_limit;
        end
    end

    b64u_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_limit (r_limit),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    b64u_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out       (o_out)
    );

    a_overflow_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> o_out.run_end && o_out.out_char == CHAR_NONE)
        else $error("overflow item without run end or with a character");

    a_term_iff_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.overflow |-> o_out.run_end == (o_out.out_char == CHAR_TERM))
        else $error("terminator and run end disagree");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.overflow |-> o_out.char_count != '0)
        else $error("character item with zero count");

endmodule

`default_nettype wire

// ----- sim/base64url_stream_encoder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for base64url_stream_encoder: directed and random
// messages, limit writes and back-pressure. Depends on b64u_pkg and the interfaces.

module base64url_stream_encoder_tb;
    import b64u_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STALL_CYCLES   = 300;

    // URL-safe alphabet, first character in the top byte
    localparam logic [8*64-1:0] URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    logic clk;
    logic rst_n;

    b64u_in_if  in_ch ();
    b64u_cfg_if cfg_ch ();
    b64u_out_if out_ch ();

    base64url_stream_encoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Encoder state as predicted
    logic [LIMIT_W-1:0] limit_reg;
    logic [3:0]         left_bits;
    t_left              left_state;
    logic [LIMIT_W-1:0] run_count;
    logic               dropping;

    t_result expected_chars[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int fail_count;
    int bytes_sent;
    int chars_checked;
    int overflows_seen;
    int limit_writes;
    int quiet_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [CHAR_W-1:0] url_code(input logic [5:0] idx);
        return URL_ALPHABET[8 * (63 - int'(idx)) +: CHAR_W];
    endfunction

    function automatic void clear_run();
        left_bits  = 4'd0;
        left_state = LEFT_0;
        run_count  = '0;
    endfunction

    // Push one character if the run still has room under the limit
    function automatic logic emit_char(input logic [CHAR_W-1:0] ch, input logic term);
        t_result r;
        if (run_count >= limit_reg) return 1'b0;
        run_count    = run_count + 16'd1;
        r.out_char   = ch;
        r.run_end    = term;
        r.overflow   = 1'b0;
        r.char_count = run_count;
        expected_chars = {expected_chars, r};
        return 1'b1;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        int      acc;
        int      nbits;
        logic    ok;
        t_result ovf;
        if (dropping) begin
            if (last) begin
                dropping = 1'b0;
                clear_run();
            end
            return;
        end
        acc   = {20'd0, left_bits, b};
        nbits = 8 + 2 * int'(left_state);
        ok    = 1'b1;
        while (ok && nbits >= 6) begin
            nbits = nbits - 6;
            ok = emit_char(url_code(6'((acc >> nbits) & 63)), 1'b0);
        end
        if (ok) begin
            left_bits  = 4'(acc & ((1 << nbits) - 1));
            left_state = t_left'(nbits / 2);
            if (last) begin
                if (nbits > 0)
                    ok = emit_char(url_code(6'(int'(left_bits) << (6 - nbits))), 1'b0);
                if (ok) ok = emit_char(CHAR_TERM, 1'b1);
                if (ok) clear_run();
            end
        end
        if (!ok) begin
            ovf.out_char   = CHAR_NONE;
            ovf.run_end    = 1'b1;
            ovf.overflow   = 1'b1;
            ovf.char_count = run_count;
            expected_chars = {expected_chars, ovf};
            clear_run();
            dropping = !last;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Offer one byte, hold it until accepted; call at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.final_byte <= last;
        do @(posedge clk); while (!in_ch.ready);
        predict_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait for every expected character plus some slack
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.out_limit <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        limit_reg = value;
        limit_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_message(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Short messages at the reset limit: leftovers of zero, two and four bits
    task automatic test_encoding();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        wait_idle();
    endtask

    // Exact fit, overflow on data, pad and terminator, dropping, zero limit
    task automatic test_limit_extremes();
        write_limit(16'd1);
        send_byte(8'hA5, 1'b1);
        wait_idle();
        write_limit(16'd3);
        send_byte(8'h3C, 1'b1);
        wait_idle();
        write_limit(16'd2);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
        send_byte(8'h9A, 1'b1);
        wait_idle();
        write_limit(16'd0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);
        wait_idle();
        write_limit(16'hFFFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
    endtask

    // Hold the result side off while bytes keep coming, then drain fully
    task automatic test_result_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_left = STALL_CYCLES;
        @(negedge clk);
        repeat (4) send_message(8);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_bytes, input int s_pct, input int r_pct);
        int stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(7) == 0) begin
                wait_idle();
                case ($urandom_range(5))
                    0:       write_limit(16'd1);
                    1:       write_limit(16'($urandom_range(4, 2)));
                    2:       write_limit(16'($urandom_range(20, 5)));
                    3:       write_limit(16'hFFFF);
                    4:       write_limit(16'($urandom_range(65535, 1)));
                    default: write_limit(LIMIT_RESET);
                endcase
            end
            if ($urandom_range(4) == 0)
                send_message($urandom_range(40, 7));
            else
                send_message($urandom_range(6, 1));
        end
        wait_idle();
    endtask

    // Receiver: long hold-off when requested, random stalls otherwise
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("item with nothing expected, out_char", out_ch.out_char, 0);
            end else begin
                want = expected_chars.pop_front();
                if (out_ch.out_char !== want.out_char)
                    report_mismatch("out_char", out_ch.out_char, want.out_char);
                if (out_ch.run_end !== want.run_end)
                    report_mismatch("run_end", out_ch.run_end, want.run_end);
                if (out_ch.overflow !== want.overflow)
                    report_mismatch("overflow", out_ch.overflow, want.overflow);
                if (out_ch.char_count !== want.char_count)
                    report_mismatch("char_count", out_ch.char_count, want.char_count);
                if (want.overflow) overflows_seen++;
            end
            chars_checked++;
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d items still expected",
                     quiet_cycles, expected_chars.size());
            $display("base64url_stream_encoder_tb NOT OK");
            $finish;
        end
    end

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.final_byte = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.out_limit = '0;
        out_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_left        = 0;
        fail_count       = 0;
        bytes_sent       = 0;
        chars_checked    = 0;
        overflows_seen   = 0;
        limit_writes     = 0;
        quiet_cycles     = 0;
        limit_reg        = LIMIT_RESET;
        dropping         = 1'b0;
        clear_run();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_encoding();
        test_limit_extremes();
        test_random_traffic(105, 21, 60);
        test_random_traffic(105, 60, 21);
        test_result_stall();
        test_random_traffic(85, 0, 0);

        $display("covered %0d bytes, %0d result items checked (%0d overflows), %0d limit writes",
                 bytes_sent, chars_checked, overflows_seen, limit_writes);
        $display("with sender and receiver stalls, a long result hold-off and %0d mismatches",
                 fail_count);
        if (fail_count == 0) begin
            $display("base64url_stream_encoder_tb OK");
        end else begin
            $display("base64url_stream_encoder_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- base64url_stream_encoder.f -----
hdl/b64u_pkg.sv
hdl/b64u_in_if.sv
hdl/b64u_out_if.sv
hdl/b64u_cfg_if.sv
hdl/b64u_step.sv
hdl/b64u_out_reg.sv
hdl/base64url_stream_encoder.sv
sim/base64url_stream_encoder_tb.sv
